### design/pata_pkg.sv
// pata_pkg: shared types and constants of the pedal assist throttle arbiter
// holds the item structs, status codes, road scaling constants and assist table
// no dependencies
package pata_pkg;

  localparam int PCT_W         = 7;
  localparam int LEVEL_IN_W    = 8;
  localparam int ASSIST_LEVELS = 5;
  localparam int LVL_W         = $clog2(ASSIST_LEVELS + 1);

  localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
  localparam logic [PCT_W-1:0] FULL_SCALE = 7'd101;
  localparam logic [PCT_W-1:0] LIMIT_MIN  = 7'd1;
  localparam logic [PCT_W-1:0] LIMIT_RST  = 7'd40;

  // floor(x/101) == (x*RECIP) >> SCALE_SHIFT for every x up to 100*101
  localparam int SCALE_SHIFT = 20;
  localparam int RECIP       = (2**SCALE_SHIFT + 101 - 1) / 101;
  localparam int FACTOR_W    = 20;
  localparam int PROD_W      = FACTOR_W + PCT_W;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'((40 - 1) * RECIP);

  localparam logic STATUS_NONE    = 1'b0;
  localparam logic STATUS_KEY_OFF = 1'b1;

  typedef logic [ASSIST_LEVELS:0][PCT_W-1:0] assist_tab_t;

  function automatic assist_tab_t build_assist_tab();
    assist_tab_t tab;
    for (int i = 0; i <= ASSIST_LEVELS; i++) begin
      tab[i] = PCT_W'((i * 100) / ASSIST_LEVELS);
    end
    return tab;
  endfunction

  localparam assist_tab_t ASSIST_TAB = build_assist_tab();

  typedef struct packed {
    logic                  key_on;
    logic                  aux_brake_on;
    logic                  brake_on;
    logic                  cruise_request;
    logic                  throttle_active;
    logic [PCT_W-1:0]      throttle_percent;
    logic                  pedalling;
    logic [LEVEL_IN_W-1:0] assist_level;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] drive_percent;
    logic             show_brake;
    logic             show_cruise;
    logic             show_throttle;
    logic             show_assist;
    logic             status_code;
  } out_item_t;

endpackage

### design/pedal_assist_throttle_arbiter.sv
// pedal_assist_throttle_arbiter: picks the motor drive percent for each control tick
// depends on pata_pkg for item structs, constants and the assist table
//
// usage:
//   in channel: one item per control tick (key, brakes, cruise request, throttle,
//   pedal sensor, assist level); accepted when in_valid is high and in_stall low.
//   out channel: one result item per input item, in order; taken when out_valid
//   is high and out_stall low. cfg channel: writes road_limit (cfg_ready is
//   always high); write it only while no item is in flight.
//   an accepted item sits in the input register, and its result is written to the
//   output register, raising out_valid, as soon as the output can advance; a
//   receiver stall holds it in the input register. throughput: one item per cycle
//   while the receiver does not stall; the path between the two registers is one
//   7x20 multiply for the road scaling and some selection.
//   the road scale factor is precomputed when the limit is written.
//   reset (rst, synchronous): road_limit returns to 40, cruise, mode and display
//   flags clear, both registers empty.
//   when the receiver stalls, the output holds and the input register keeps its
//   item; in_stall rises only once the input register is full and cannot move.
module pedal_assist_throttle_arbiter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pata_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pata_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [pata_pkg::PCT_W-1:0] cfg_data
);

  // road scale factor, (limit-1) * reciprocal of 101
  logic [pata_pkg::FACTOR_W-1:0] factor;
  logic [pata_pkg::FACTOR_W-1:0] factor_next;
  logic [pata_pkg::PCT_W-1:0]    lim_clamped;
  logic [pata_pkg::PCT_W-1:0]    lim_m1;

  logic                s1_valid;
  pata_pkg::in_item_t  s1_item;
  logic                advance;
  logic                accept;

  // arbitration state
  logic                       cruise_active, cruise_active_next;
  logic [pata_pkg::PCT_W-1:0] cruise_level, cruise_level_next;
  logic                       unrestricted_mode, unrestricted_mode_next;
  logic                       brake_flag, brake_flag_next;
  logic                       cruise_flag, cruise_flag_next;
  logic                       throttle_flag, throttle_flag_next;
  logic                       assist_flag, assist_flag_next;

  logic [pata_pkg::PCT_W-1:0]  pct_sat;
  logic [pata_pkg::PCT_W-1:0]  pct_plus1;
  logic [pata_pkg::LVL_W-1:0]  lvl_sat;
  logic [pata_pkg::PCT_W-1:0]  value;
  logic [pata_pkg::PROD_W-1:0] prod;
  logic [pata_pkg::PCT_W-1:0]  drive;
  logic                        status;
  pata_pkg::out_item_t         result;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < pata_pkg::LIMIT_MIN) begin
      lim_clamped = pata_pkg::LIMIT_MIN;
    end else if (cfg_data > pata_pkg::FULL_SCALE) begin
      lim_clamped = pata_pkg::FULL_SCALE;
    end else begin
      lim_clamped = cfg_data;
    end
    lim_m1      = lim_clamped - 7'd1;
    factor_next = pata_pkg::FACTOR_W'(pata_pkg::FACTOR_W'(lim_m1) *
                                      pata_pkg::FACTOR_W'(pata_pkg::RECIP));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= pata_pkg::FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      factor <= factor_next;
    end
  end

  // input register and handshake
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_data;
    end
  end

  always_comb begin
    if (s1_item.throttle_percent > pata_pkg::PCT_MAX) begin
      pct_sat = pata_pkg::PCT_MAX;
    end else begin
      pct_sat = s1_item.throttle_percent;
    end
    pct_plus1 = pct_sat + 7'd1;

    if (s1_item.assist_level > pata_pkg::LEVEL_IN_W'(pata_pkg::ASSIST_LEVELS)) begin
      lvl_sat = pata_pkg::LVL_W'(pata_pkg::ASSIST_LEVELS);
    end else begin
      lvl_sat = s1_item.assist_level[pata_pkg::LVL_W-1:0];
    end

    cruise_active_next     = cruise_active;
    cruise_level_next      = cruise_level;
    unrestricted_mode_next = unrestricted_mode;
    brake_flag_next        = brake_flag;
    cruise_flag_next       = cruise_flag;
    throttle_flag_next     = throttle_flag;
    assist_flag_next       = assist_flag;
    value                  = '0;
    status                 = pata_pkg::STATUS_NONE;

    if (!s1_item.key_on) begin
      cruise_flag_next       = 1'b0;
      status                 = pata_pkg::STATUS_KEY_OFF;
      unrestricted_mode_next = s1_item.aux_brake_on;
    end else begin
      if (s1_item.cruise_request) begin
        cruise_active_next = 1'b1;
      end
      if (s1_item.brake_on) begin
        brake_flag_next    = 1'b1;
        cruise_active_next = 1'b0;
        cruise_flag_next   = 1'b0;
        value              = '0;
      end else begin
        brake_flag_next = 1'b0;
        if (cruise_active_next) begin
          // cruise level is captured only while none is held
          if (cruise_level == '0) begin
            cruise_level_next = pct_plus1;
          end
          cruise_flag_next   = 1'b1;
          throttle_flag_next = 1'b0;
          assist_flag_next   = 1'b0;
          value              = cruise_level_next;
        end else begin
          cruise_level_next = '0;
          cruise_flag_next  = 1'b0;
          if (s1_item.throttle_active) begin
            throttle_flag_next = 1'b1;
            assist_flag_next   = 1'b0;
            value              = pct_plus1;
          end else begin
            throttle_flag_next = 1'b0;
            if (s1_item.pedalling && (lvl_sat != '0)) begin
              assist_flag_next = 1'b1;
              value            = pata_pkg::ASSIST_TAB[lvl_sat];
            end else begin
              assist_flag_next = 1'b0;
              value            = 7'd1;
            end
          end
        end
      end
    end

    // road mode: value*(limit-1)/101 + 1 for values above one
    prod = pata_pkg::PROD_W'(value) * pata_pkg::PROD_W'(factor);
    if (!s1_item.key_on) begin
      drive = '0;
    end else if (unrestricted_mode || (value <= 7'd1)) begin
      drive = value;
    end else begin
      drive = prod[pata_pkg::SCALE_SHIFT +: pata_pkg::PCT_W] + 7'd1;
    end

    result.drive_percent = drive;
    result.show_brake    = brake_flag_next;
    result.show_cruise   = cruise_flag_next;
    result.show_throttle = throttle_flag_next;
    result.show_assist   = assist_flag_next;
    result.status_code   = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_active     <= 1'b0;
      cruise_level      <= '0;
      unrestricted_mode <= 1'b0;
      brake_flag        <= 1'b0;
      cruise_flag       <= 1'b0;
      throttle_flag     <= 1'b0;
      assist_flag       <= 1'b0;
    end else if (advance && s1_valid) begin
      cruise_active     <= cruise_active_next;
      cruise_level      <= cruise_level_next;
      unrestricted_mode <= unrestricted_mode_next;
      brake_flag        <= brake_flag_next;
      cruise_flag       <= cruise_flag_next;
      throttle_flag     <= throttle_flag_next;
      assist_flag       <= assist_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled while the pipeline has room");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cruise_flag, throttle_flag, assist_flag}))
    else $error("more than one drive source flag set");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status_code == pata_pkg::STATUS_KEY_OFF)
    |-> out_data.drive_percent == '0)
    else $error("nonzero drive with key off");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.show_brake && (out_data.status_code == pata_pkg::STATUS_NONE)
    |-> out_data.drive_percent == '0 && !out_data.show_cruise)
    else $error("drive or cruise while braking");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.drive_percent <= pata_pkg::FULL_SCALE)
    else $error("drive percent above full scale");

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for pedal_assist_throttle_arbiter
// drives control ticks and road limit writes and checks every drive item
// against an in-bench predictor; depends on design/pata_pkg.sv and the rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_TICKS = 220;
  localparam int MAX_LINES   = 60;

  class drive_scoreboard;
    pata_pkg::out_item_t        expected_q[$];
    int unsigned                mismatches;
    int unsigned                result_idx;
    logic [pata_pkg::PCT_W-1:0] road_limit;
    logic                       cruise_on;
    logic [pata_pkg::PCT_W-1:0] cruise_pct;
    logic                       unrestricted;
    logic                       brake_ind;
    logic                       cruise_ind;
    logic                       throttle_ind;
    logic                       assist_ind;
    logic [pata_pkg::PCT_W-1:0] drive_pct;

    function new();
      mismatches   = 0;
      result_idx   = 0;
      road_limit   = pata_pkg::LIMIT_RST;
      cruise_on    = 1'b0;
      cruise_pct   = '0;
      unrestricted = 1'b0;
      brake_ind    = 1'b0;
      cruise_ind   = 1'b0;
      throttle_ind = 1'b0;
      assist_ind   = 1'b0;
      drive_pct    = '0;
    endfunction

    function void set_road_limit(logic [pata_pkg::PCT_W-1:0] v);
      road_limit = v;
    endfunction

    // 0 and 1 pass, the rest is squeezed to at most the road limit
    function logic [pata_pkg::PCT_W-1:0] road_scaled(logic [pata_pkg::PCT_W-1:0] v);
      logic [pata_pkg::PCT_W-1:0] lim;
      logic [13:0]                prod;
      lim = road_limit;
      if (lim < pata_pkg::LIMIT_MIN) lim = pata_pkg::LIMIT_MIN;
      if (lim > pata_pkg::FULL_SCALE) lim = pata_pkg::FULL_SCALE;
      if (v <= 7'd1) return v;
      prod = 14'(v) * 14'(lim - 7'd1);
      return pata_pkg::PCT_W'(prod / 14'(pata_pkg::FULL_SCALE)) + 7'd1;
    endfunction

    function void note_tick(pata_pkg::in_item_t t);
      logic [pata_pkg::PCT_W-1:0]      pct;
      logic [pata_pkg::LEVEL_IN_W-1:0] lvl;
      logic [pata_pkg::PCT_W-1:0]      demand;
      pata_pkg::out_item_t             e;
      pct = (t.throttle_percent > pata_pkg::PCT_MAX) ? pata_pkg::PCT_MAX :
                                                       t.throttle_percent;
      lvl = (t.assist_level > pata_pkg::ASSIST_LEVELS) ?
            pata_pkg::LEVEL_IN_W'(pata_pkg::ASSIST_LEVELS) : t.assist_level;
      demand = '0;
      e.status_code = pata_pkg::STATUS_NONE;
      if (!t.key_on) begin
        drive_pct     = '0;
        cruise_ind    = 1'b0;
        e.status_code = pata_pkg::STATUS_KEY_OFF;
        unrestricted  = t.aux_brake_on;
      end else begin
        if (t.cruise_request) cruise_on = 1'b1;
        if (t.brake_on) begin
          brake_ind  = 1'b1;
          cruise_on  = 1'b0;
          cruise_ind = 1'b0;
        end else begin
          brake_ind = 1'b0;
          if (cruise_on) begin
            // level is latched while none is held and kept until a key-on tick with no brake and no cruise
            if (cruise_pct == '0) cruise_pct = pct + 7'd1;
            cruise_ind   = 1'b1;
            throttle_ind = 1'b0;
            assist_ind   = 1'b0;
            demand       = cruise_pct;
          end else begin
            cruise_pct = '0;
            cruise_ind = 1'b0;
            if (t.throttle_active) begin
              throttle_ind = 1'b1;
              assist_ind   = 1'b0;
              demand       = pct + 7'd1;
            end else begin
              throttle_ind = 1'b0;
              if (t.pedalling && lvl != '0) begin
                assist_ind = 1'b1;
                demand     = pata_pkg::PCT_W'(10'(lvl) * 10'd100 /
                                              10'(pata_pkg::ASSIST_LEVELS));
              end else begin
                assist_ind = 1'b0;
                demand     = 7'd1;
              end
            end
          end
        end
        drive_pct = unrestricted ? demand : road_scaled(demand);
      end
      e.drive_percent = drive_pct;
      e.show_brake    = brake_ind;
      e.show_cruise   = cruise_ind;
      e.show_throttle = throttle_ind;
      e.show_assist   = assist_ind;
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      if (mismatches < MAX_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("item %0d %s got %0d want %0d", result_idx, name, got, want));
    endtask

    task check_result(pata_pkg::out_item_t got);
      pata_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = expected_q.pop_front();
      if ($isunknown(got)) report($sformatf("item %0d has unknown bits: %h", result_idx, got));
      compare_field("drive_percent", got.drive_percent, want.drive_percent);
      compare_field("show_brake", got.show_brake, want.show_brake);
      compare_field("show_cruise", got.show_cruise, want.show_cruise);
      compare_field("show_throttle", got.show_throttle, want.show_throttle);
      compare_field("show_assist", got.show_assist, want.show_assist);
      compare_field("status_code", got.status_code, want.status_code);
      result_idx++;
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  pata_pkg::in_item_t         in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  pata_pkg::out_item_t        out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [pata_pkg::PCT_W-1:0] cfg_data = '0;

  drive_scoreboard sb;
  bit              calm = 1'b0;
  bit              hold_request = 1'b0;
  int              hold_left = 0;
  int              quiet_cycles = 0;

  pedal_assist_throttle_arbiter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, none while calm, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_tick(in_data);
      if (cfg_valid && cfg_ready) sb.set_road_limit(cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pata_pkg::in_item_t tick_of(logic key, logic aux, logic brk,
                                                 logic creq, logic thr,
                                                 logic [pata_pkg::PCT_W-1:0] pct,
                                                 logic ped,
                                                 logic [pata_pkg::LEVEL_IN_W-1:0] lvl);
    pata_pkg::in_item_t t;
    t.key_on           = key;
    t.aux_brake_on     = aux;
    t.brake_on         = brk;
    t.cruise_request   = creq;
    t.throttle_active  = thr;
    t.throttle_percent = pct;
    t.pedalling        = ped;
    t.assist_level     = lvl;
    return t;
  endfunction

  // mostly key-on riding with cruise, throttle and assist mixed in;
  // some key-off ticks flip the road mode, some fields run out of range
  function automatic pata_pkg::in_item_t random_tick();
    logic [pata_pkg::PCT_W-1:0]      pct;
    logic [pata_pkg::LEVEL_IN_W-1:0] lvl;
    pct = ($urandom_range(99) < 90) ? pata_pkg::PCT_W'($urandom_range(100)) :
                                      pata_pkg::PCT_W'($urandom_range(127, 101));
    lvl = ($urandom_range(99) < 80) ? pata_pkg::LEVEL_IN_W'($urandom_range(6)) :
                                      pata_pkg::LEVEL_IN_W'($urandom_range(255));
    return tick_of($urandom_range(99) >= 6, 1'($urandom_range(1)),
                   $urandom_range(99) < 12, $urandom_range(99) < 8,
                   $urandom_range(99) < 45, pct, 1'($urandom_range(1)), lvl);
  endfunction

  task automatic send_tick(pata_pkg::in_item_t t);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the last accepted item reach the scoreboard first
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    // pipeline is two registers deep
    repeat (4) @(posedge clk);
  endtask

  task automatic write_road_limit(logic [pata_pkg::PCT_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [pata_pkg::PCT_W-1:0] limits[8];
    sb = new();
    limits = '{7'd101, 7'd1, 7'd0, 7'd127, 7'd40, 7'd2, 7'd0, 7'd0};
    limits[6] = pata_pkg::PCT_W'($urandom_range(101, 1));
    limits[7] = pata_pkg::PCT_W'($urandom);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks at the reset road limit
    send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 0, 1, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 0, 1, 100, 0, 0));
    // out-of-range throttle saturates, throttle beats assist
    send_tick(tick_of(1, 0, 0, 0, 1, 127, 1, 255));
    for (int lvl = 0; lvl <= pata_pkg::ASSIST_LEVELS; lvl++)
      send_tick(tick_of(1, 0, 0, 0, 0, 7'h55, 1, pata_pkg::LEVEL_IN_W'(lvl)));
    send_tick(tick_of(1, 0, 0, 0, 0, 0, 1, 255));
    send_tick(tick_of(1, 0, 0, 0, 0, 0, 0, 5));
    send_tick(tick_of(1, 1, 1, 0, 1, 100, 1, 3));
    send_tick(tick_of(1, 0, 0, 1, 1, 50, 0, 0));
    send_tick(tick_of(1, 0, 0, 0, 1, 10, 1, 2));
    // brake cancels cruise even with a request on the same tick
    send_tick(tick_of(1, 0, 1, 1, 0, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 1, 0, 0, 0, 0));
    // key off keeps cruise, aux brake unlocks the road limit
    send_tick(tick_of(0, 1, 0, 1, 1, 90, 1, 5));
    send_tick(tick_of(1, 0, 0, 0, 0, 99, 0, 0));
    send_tick(tick_of(1, 0, 1, 0, 0, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 1, 0, 127, 0, 0));
    send_tick(tick_of(1, 0, 1, 0, 0, 0, 0, 0));
    send_tick(tick_of(1, 0, 0, 0, 1, 100, 0, 0));
    send_tick(tick_of(1, 0, 0, 0, 0, 0, 1, 5));
    send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0));

    foreach (limits[p]) begin
      write_road_limit(limits[p]);
      calm = (p == 3);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // long receiver hold while ticks keep coming
        if (p == 1 && n == 80) hold_request = 1'b1;
        send_tick(random_tick());
      end
    end
    calm = 1'b0;

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
